/* design/patch_column_post_decoder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the patch column post decoder
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PATCH_COLUMN_POST_DECODER_ASSERT_SVH
`define PATCH_COLUMN_POST_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PCPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PCPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pcpd_pkg.sv */
// ----------------------------------------------------------------------------
// Patch column post decoder package
// Types, codes and widths shared by the decoder modules.
// ----------------------------------------------------------------------------
package pcpd_pkg;

    localparam logic [7:0] END_MARK = 8'hFF;

    // Result kinds, carried on m_tuser
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_TRUNC = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_ODD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_TRANS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd5;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 56;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_TOP  = 5'b00010,
        PH_LEN  = 5'b00100,
        PH_PIX  = 5'b01000,
        PH_PAD  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic        pad_after_odd;
        logic        zero_transparent;
        logic        clip_enable;
        logic [8:0]  column_height;
        logic [16:0] origin_x;
        logic [16:0] origin_y;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [17:0] screen_x;
        logic [17:0] screen_y;
        logic [8:0]  row;
        logic [7:0]  pixel_value;
    } result_t;

endpackage

/* design/patch_column_post_decoder.sv */
// A result beat appears on the master side in the cycle after its byte is taken.
// Throughput: one byte per cycle; the slave side stalls only while a held result
// is not taken, since the single result register is the only buffer.
// Reset: aresetn low at a clock edge empties the result register, returns the
// decoder to idle and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// Patch column post decoder
// Turns a byte stream of column posts into pixel writes and column status beats.
// ----------------------------------------------------------------------------
`include "patch_column_post_decoder_assert.svh"

module patch_column_post_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pcpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // byte_value[7:0], column_index[16:8], zero fill
    input  logic [pcpd_pkg::S_TDATA_W-1:0]  s_tdata,
    // start_column[0]
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // screen_x[17:0], screen_y[35:18], row[44:36], pixel_value[52:45], zero fill
    output logic [pcpd_pkg::M_TDATA_W-1:0]  m_tdata,
    // kind[1:0]
    output logic [1:0]                      m_tuser
);

    pcpd_pkg::cfg_t    cfg;
    pcpd_pkg::result_t res;
    logic              accept;
    logic              dec_idle;

    assign s_tready = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;

    pcpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pcpd_decoder u_decoder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .byte_value   (s_tdata[7:0]),
        .start_column (s_tuser),
        .column_index (s_tdata[16:8]),
        .last_byte    (s_tlast),
        .cfg          (cfg),
        .res          (res),
        .idle         (dec_idle)
    );

    pcpd_outreg u_outreg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `PCPD_ASSERT_NOW(a_status_zero_data, m_tvalid && (m_tuser != pcpd_pkg::KIND_PIXEL), m_tdata == '0, "status beat carries non-zero data")
    `PCPD_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "slave side stalled with empty result register")
    `PCPD_ASSERT_NEXT(a_idle_after_last, accept && s_tlast, dec_idle, "decoder not idle after the last beat")
    `PCPD_ASSERT_NOW(a_trunc_needs_last, accept && res.valid && (res.kind == pcpd_pkg::KIND_TRUNC), s_tlast, "truncation reported without a last beat")

endmodule

/* design/pcpd_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the six control registers written through the plain write port.
// ----------------------------------------------------------------------------
module pcpd_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pcpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output pcpd_pkg::cfg_t                  cfg
);

    pcpd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pad_after_odd    <= 1'b1;
            cfg_reg.zero_transparent <= 1'b1;
            cfg_reg.clip_enable      <= 1'b0;
            cfg_reg.column_height    <= 9'd511;
            cfg_reg.origin_x         <= 17'd0;
            cfg_reg.origin_y         <= 17'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pcpd_pkg::REG_PAD_ODD:    cfg_reg.pad_after_odd    <= cfg_wdata[0];
                pcpd_pkg::REG_ZERO_TRANS: cfg_reg.zero_transparent <= cfg_wdata[0];
                pcpd_pkg::REG_CLIP_EN:    cfg_reg.clip_enable      <= cfg_wdata[0];
                pcpd_pkg::REG_HEIGHT:     cfg_reg.column_height    <= cfg_wdata[8:0];
                pcpd_pkg::REG_ORIGIN_X:   cfg_reg.origin_x         <= cfg_wdata[16:0];
                pcpd_pkg::REG_ORIGIN_Y:   cfg_reg.origin_y         <= cfg_wdata[16:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/pcpd_decoder.sv */
// ----------------------------------------------------------------------------
// Post stream decoder
// Phase machine and pixel address arithmetic, one byte per accepted beat.
// ----------------------------------------------------------------------------
module pcpd_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        byte_value,
    input  logic              start_column,
    input  logic [8:0]        column_index,
    input  logic              last_byte,
    input  pcpd_pkg::cfg_t    cfg,
    output pcpd_pkg::result_t res,
    output logic              idle
);

    pcpd_pkg::phase_t phase_reg, phase_next, eff_phase;
    logic [7:0] post_top_reg, post_top_next;
    logic [7:0] pixels_left_reg, pixels_left_next;
    logic [7:0] row_in_post_reg, row_in_post_next;
    logic       odd_length_reg, odd_length_next;
    logic [8:0] current_column_reg, current_column_next;

    logic [8:0] col;
    logic [8:0] row;
    logic       skip;
    logic       trunc_check;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= pcpd_pkg::PH_IDLE;
            post_top_reg       <= 8'd0;
            pixels_left_reg    <= 8'd0;
            row_in_post_reg    <= 8'd0;
            odd_length_reg     <= 1'b0;
            current_column_reg <= 9'd0;
        end else begin
            phase_reg          <= phase_next;
            post_top_reg       <= post_top_next;
            pixels_left_reg    <= pixels_left_next;
            row_in_post_reg    <= row_in_post_next;
            odd_length_reg     <= odd_length_next;
            current_column_reg <= current_column_next;
        end
    end

    assign eff_phase = start_column ? pcpd_pkg::PH_TOP : phase_reg;
    assign col       = start_column ? column_index : current_column_reg;
    assign row       = {1'b0, post_top_reg} + {1'b0, row_in_post_reg};
    assign skip      = (cfg.zero_transparent && (byte_value == 8'd0)) ||
                       (cfg.clip_enable && (row >= cfg.column_height));

    always_comb begin
        phase_next          = phase_reg;
        post_top_next       = post_top_reg;
        pixels_left_next    = pixels_left_reg;
        row_in_post_next    = row_in_post_reg;
        odd_length_next     = odd_length_reg;
        current_column_next = current_column_reg;
        trunc_check         = 1'b0;
        res                 = '0;

        if (accept) begin
            current_column_next = col;
            unique case (eff_phase)
                pcpd_pkg::PH_TOP: begin
                    // The terminator ends the column even on the last beat.
                    if (byte_value == pcpd_pkg::END_MARK) begin
                        phase_next = pcpd_pkg::PH_IDLE;
                        res.valid  = 1'b1;
                        res.kind   = pcpd_pkg::KIND_DONE;
                    end else begin
                        post_top_next = byte_value;
                        phase_next    = pcpd_pkg::PH_LEN;
                        trunc_check   = 1'b1;
                    end
                end
                pcpd_pkg::PH_LEN: begin
                    pixels_left_next = byte_value;
                    row_in_post_next = 8'd0;
                    odd_length_next  = byte_value[0];
                    phase_next       = (byte_value == 8'd0) ? pcpd_pkg::PH_TOP
                                                            : pcpd_pkg::PH_PIX;
                    trunc_check      = 1'b1;
                end
                pcpd_pkg::PH_PIX: begin
                    if (!skip) begin
                        res.valid       = 1'b1;
                        res.kind        = pcpd_pkg::KIND_PIXEL;
                        res.screen_x    = {cfg.origin_x[16], cfg.origin_x} + {9'd0, col};
                        res.screen_y    = {cfg.origin_y[16], cfg.origin_y} + {9'd0, row};
                        res.row         = row;
                        res.pixel_value = byte_value;
                    end
                    row_in_post_next = row_in_post_reg + 8'd1;
                    pixels_left_next = pixels_left_reg - 8'd1;
                    if (pixels_left_reg == 8'd1) begin
                        phase_next = (cfg.pad_after_odd && odd_length_reg)
                                     ? pcpd_pkg::PH_PAD : pcpd_pkg::PH_TOP;
                    end
                    trunc_check = 1'b1;
                end
                pcpd_pkg::PH_PAD: begin
                    phase_next  = pcpd_pkg::PH_TOP;
                    trunc_check = 1'b1;
                end
                default: begin
                    phase_next = pcpd_pkg::PH_IDLE;
                end
            endcase

            // Running out of data mid-column overrides any pixel write.
            if (trunc_check && last_byte) begin
                phase_next = pcpd_pkg::PH_IDLE;
                res        = '0;
                res.valid  = 1'b1;
                res.kind   = pcpd_pkg::KIND_TRUNC;
            end
        end
    end

    assign idle = (phase_reg == pcpd_pkg::PH_IDLE);

endmodule

/* design/pcpd_outreg.sv */
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat for the master side and packs its tdata and tuser.
// ----------------------------------------------------------------------------
module pcpd_outreg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  pcpd_pkg::result_t              res,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // screen_x[17:0], screen_y[35:18], row[44:36], pixel_value[52:45], zero fill
    output logic [pcpd_pkg::M_TDATA_W-1:0] m_tdata,
    // kind[1:0]
    output logic [1:0]                     m_tuser
);

    logic                           valid_reg;
    logic [pcpd_pkg::M_TDATA_W-1:0] data_reg;
    logic [1:0]                     kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load && res.valid) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res.valid) begin
            data_reg <= {3'd0, res.pixel_value, res.row, res.screen_y, res.screen_x};
            kind_reg <= res.kind;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

endmodule

/* tb/sv/tb_patch_column_post_decoder.sv */
// ----------------------------------------------------------------------------
// Testbench for the patch column post decoder
// Streams column post bytes into the decoder. Directed columns come first, then
// register extremes, a long output stall and random columns. Every result beat
// is checked against a local decoder model, with random gaps on the input side
// and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb_patch_column_post_decoder;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEM_TARGET     = 1750;
    localparam int HOLD_OFF_CYCLES = 300;

    // Indexes past the end of the register map; writes to them must do nothing.
    localparam logic [pcpd_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [pcpd_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;
    typedef enum {FAULT_NONE, FAULT_TRUNC, FAULT_RESTART} fault_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [17:0] screen_x;
        logic [17:0] screen_y;
        logic [8:0]  row;
        logic [7:0]  pixel_value;
    } column_write_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [pcpd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pcpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    // byte_value[7:0], column_index[16:8], zero fill
    logic [pcpd_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    // start_column[0]
    logic                            s_tuser   = 1'b0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // screen_x[17:0], screen_y[35:18], row[44:36], pixel_value[52:45], zero fill
    logic [pcpd_pkg::M_TDATA_W-1:0]  m_tdata;
    // kind[1:0]
    logic [1:0]                      m_tuser;

    // Decoder model: registers and state
    logic             cfg_pad_odd    = 1'b1;
    logic             cfg_zero_trans = 1'b1;
    logic             cfg_clip       = 1'b0;
    logic [8:0]       cfg_height     = 9'd511;
    logic [16:0]      cfg_origin_x   = '0;
    logic [16:0]      cfg_origin_y   = '0;
    pcpd_pkg::phase_t dec_phase      = pcpd_pkg::PH_IDLE;
    logic [7:0]       post_top       = '0;
    logic [7:0]       pixels_left    = '0;
    logic [7:0]       row_in_post    = '0;
    logic             odd_length     = 1'b0;
    logic [8:0]       cur_column     = '0;

    column_write_t expected_writes[$];
    int            decoded_count = 0;
    int            error_count   = 0;
    int            cycle_count;

    // Sender and receiver pacing
    int       burst_left    = 0;
    bit       sender_steady = 1'b0;
    int       col_pos;
    int       fault_at;
    fault_t   fault_kind;
    rx_mode_t rx_mode       = RX_OPEN;
    int       rx_span       = 0;
    logic [7:0] rx_pattern  = 8'hFF;
    logic     hold_active   = 1'b0;
    event     hold_off_request;

    patch_column_post_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Advances the model by one accepted byte and queues the write it causes.
    function automatic void decode_byte(input logic [7:0] b, input bit start,
                                        input logic [8:0] col, input bit last);
        column_write_t w;
        logic [8:0]    r;
        bit            emit;
        w    = '0;
        emit = 1'b0;
        if (!start && dec_phase == pcpd_pkg::PH_IDLE)
            return;
        decoded_count++;
        if (start) begin
            cur_column = col;
            dec_phase  = pcpd_pkg::PH_TOP;
        end
        case (dec_phase)
            pcpd_pkg::PH_TOP: begin
                if (b == pcpd_pkg::END_MARK) begin
                    dec_phase = pcpd_pkg::PH_IDLE;
                    w.kind    = pcpd_pkg::KIND_DONE;
                    expected_writes.push_back(w);
                    return;
                end
                post_top  = b;
                dec_phase = pcpd_pkg::PH_LEN;
            end
            pcpd_pkg::PH_LEN: begin
                pixels_left = b;
                row_in_post = '0;
                odd_length  = b[0];
                if (b == 8'd0)
                    dec_phase = pcpd_pkg::PH_TOP;
                else
                    dec_phase = pcpd_pkg::PH_PIX;
            end
            pcpd_pkg::PH_PIX: begin
                r = {1'b0, post_top} + {1'b0, row_in_post};
                if (!((cfg_zero_trans && b == 8'd0) || (cfg_clip && r >= cfg_height))) begin
                    emit          = 1'b1;
                    w.kind        = pcpd_pkg::KIND_PIXEL;
                    w.screen_x    = {cfg_origin_x[16], cfg_origin_x} + {9'd0, cur_column};
                    w.screen_y    = {cfg_origin_y[16], cfg_origin_y} + {9'd0, r};
                    w.row         = r;
                    w.pixel_value = b;
                end
                row_in_post = row_in_post + 8'd1;
                pixels_left = pixels_left - 8'd1;
                if (pixels_left == 8'd0) begin
                    if (cfg_pad_odd && odd_length)
                        dec_phase = pcpd_pkg::PH_PAD;
                    else
                        dec_phase = pcpd_pkg::PH_TOP;
                end
            end
            pcpd_pkg::PH_PAD: dec_phase = pcpd_pkg::PH_TOP;
            default: dec_phase = pcpd_pkg::PH_IDLE;
        endcase
        // Running out of data overrides whatever this byte would have written.
        if (last) begin
            dec_phase = pcpd_pkg::PH_IDLE;
            w         = '0;
            w.kind    = pcpd_pkg::KIND_TRUNC;
            emit      = 1'b1;
        end
        if (emit)
            expected_writes.push_back(w);
    endfunction

    function automatic void compare_field(input string name, input logic [17:0] want,
                                          input logic [17:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic check_result_beat();
        column_write_t w;
        if (expected_writes.size() == 0) begin
            $error("result beat of kind %0d arrived with nothing pending", m_tuser);
            error_count++;
            return;
        end
        w = expected_writes.pop_front();
        compare_field("kind", 18'(w.kind), 18'(m_tuser));
        compare_field("screen_x", w.screen_x, m_tdata[17:0]);
        compare_field("screen_y", w.screen_y, m_tdata[35:18]);
        compare_field("row", 18'(w.row), 18'(m_tdata[44:36]));
        compare_field("pixel_value", 18'(w.pixel_value), 18'(m_tdata[52:45]));
    endtask

    // Receiver: checks each beat and stalls on a pattern that changes now and then.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_result_beat();
            if (rx_span == 0) begin
                rx_mode    = rx_mode_t'($urandom_range(0, 3));
                rx_span    = $urandom_range(16, 200);
                rx_pattern = 8'($urandom) | 8'h01;
            end else begin
                rx_span--;
            end
            rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
            if (hold_active) begin
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:    m_tready <= 1'b1;
                    RX_RANDOM:  m_tready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: m_tready <= rx_pattern[0];
                    default:    m_tready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // Long receiver hold-off, counted here once requested.
    initial forever begin
        @(hold_off_request);
        hold_active <= 1'b1;
        for (int n = 0; n < HOLD_OFF_CYCLES; n++)
            @(posedge aclk);
        hold_active <= 1'b0;
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input bit start,
                             input logic [8:0] col, input bit last);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (!sender_steady)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(pcpd_pkg::S_TDATA_W-17){1'b0}}, col, b};
        s_tuser  <= start;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, start, col, last);
    endtask

    // Lets every pending result drain; the extra cycles cover bytes with no result.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [pcpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [16:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            pcpd_pkg::REG_PAD_ODD:    cfg_pad_odd    = value[0];
            pcpd_pkg::REG_ZERO_TRANS: cfg_zero_trans = value[0];
            pcpd_pkg::REG_CLIP_EN:    cfg_clip       = value[0];
            pcpd_pkg::REG_HEIGHT:     cfg_height     = value[8:0];
            pcpd_pkg::REG_ORIGIN_X:   cfg_origin_x   = value;
            pcpd_pkg::REG_ORIGIN_Y:   cfg_origin_y   = value;
            default: ;
        endcase
    endtask

    // Upper bits of the narrow registers carry junk, which the block must mask off.
    task automatic set_config(input bit pad, input bit zt, input bit clip,
                              input logic [8:0] height, input logic [16:0] ox,
                              input logic [16:0] oy);
        logic [16:0] junk;
        wait_idle();
        junk = 17'($urandom);
        write_reg(pcpd_pkg::REG_PAD_ODD, {junk[16:1], pad});
        junk = 17'($urandom);
        write_reg(pcpd_pkg::REG_ZERO_TRANS, {junk[16:1], zt});
        junk = 17'($urandom);
        write_reg(pcpd_pkg::REG_CLIP_EN, {junk[16:1], clip});
        junk = 17'($urandom);
        write_reg(pcpd_pkg::REG_HEIGHT, {junk[16:9], height});
        write_reg(pcpd_pkg::REG_ORIGIN_X, ox);
        write_reg(pcpd_pkg::REG_ORIGIN_Y, oy);
        write_reg(REG_SPARE_A, 17'($urandom));
        write_reg(REG_SPARE_B, 17'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // One byte of a generated column, with the fault chosen for this column applied.
    task automatic send_col_byte(input logic [7:0] b, input bit start, input logic [8:0] col);
        bit last;
        last = 1'b0;
        if (!start)
            col = 9'($urandom_range(0, 511));
        if (col_pos == fault_at) begin
            if (fault_kind == FAULT_TRUNC) begin
                last = 1'b1;
            end else if (fault_kind == FAULT_RESTART) begin
                start = 1'b1;
                col   = 9'($urandom_range(0, 511));
            end
        end
        col_pos++;
        send_byte(b, start, col, last);
    endtask

    task automatic send_column();
        int          posts;
        int          len;
        int          pick;
        logic [8:0]  col;
        logic [7:0]  top;
        col           = 9'($urandom_range(0, 511));
        posts         = $urandom_range(0, 4);
        sender_steady = ($urandom_range(0, 4) == 0);
        col_pos       = 0;
        fault_at      = $urandom_range(0, 12);
        pick          = $urandom_range(0, 19);
        if (pick < 2)
            fault_kind = FAULT_TRUNC;
        else if (pick < 4)
            fault_kind = FAULT_RESTART;
        else
            fault_kind = FAULT_NONE;
        // Stray bytes between columns, ignored by an idle decoder.
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0, 9'($urandom_range(0, 511)),
                          1'($urandom_range(0, 1)));
        for (int p = 0; p < posts; p++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                top = 8'd254;
            else if (pick == 1)
                top = 8'd0;
            else
                top = 8'($urandom_range(0, 254));
            send_col_byte(top, p == 0, col);
            if ($urandom_range(0, 24) == 0)
                len = $urandom_range(13, 255);
            else
                len = $urandom_range(0, 12);
            send_col_byte(len[7:0], 1'b0, col);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 5) == 0)
                    send_col_byte(8'd0, 1'b0, col);
                else
                    send_col_byte(8'($urandom_range(0, 255)), 1'b0, col);
            end
            if (cfg_pad_odd && len[0])
                send_col_byte(8'($urandom_range(0, 255)), 1'b0, col);
        end
        send_col_byte(pcpd_pkg::END_MARK, posts == 0, col);
    endtask

    task automatic send_columns_for(input int items);
        int target;
        target = decoded_count + items;
        while (decoded_count < target)
            send_column();
    endtask

    task automatic test_ignored_bytes();
        send_byte(8'h00, 1'b0, 9'h1FF, 1'b0);
        send_byte(pcpd_pkg::END_MARK, 1'b0, 9'h000, 1'b1);
        send_byte(8'hA5, 1'b0, 9'h155, 1'b1);
    endtask

    // Odd post with pad, transparent zero, zero-length post and the terminator.
    task automatic test_post_layout();
        send_byte(8'd0, 1'b1, 9'd511, 1'b0);
        send_byte(8'd3, 1'b0, 9'd0, 1'b0);
        send_byte(8'd0, 1'b0, 9'd0, 1'b0);
        send_byte(8'd255, 1'b0, 9'd0, 1'b0);
        send_byte(8'd1, 1'b0, 9'd0, 1'b0);
        send_byte(pcpd_pkg::END_MARK, 1'b0, 9'd0, 1'b0);
        send_byte(8'd254, 1'b0, 9'd0, 1'b0);
        send_byte(8'd0, 1'b0, 9'd0, 1'b0);
        send_byte(pcpd_pkg::END_MARK, 1'b0, 9'd0, 1'b0);
    endtask

    task automatic test_restart_and_truncation();
        // A new column abandons the one in progress; its first byte ends it at once.
        send_byte(8'd1, 1'b1, 9'd0, 1'b0);
        send_byte(8'd2, 1'b0, 9'd0, 1'b0);
        send_byte(8'h80, 1'b0, 9'd0, 1'b0);
        send_byte(pcpd_pkg::END_MARK, 1'b1, 9'd256, 1'b0);
        // Data ends on the length byte.
        send_byte(8'd7, 1'b1, 9'd3, 1'b0);
        send_byte(8'd9, 1'b0, 9'd0, 1'b1);
        // Data ends on a pixel, which then gives no write.
        send_byte(8'd10, 1'b1, 9'd5, 1'b0);
        send_byte(8'd1, 1'b0, 9'd0, 1'b0);
        send_byte(8'h7E, 1'b0, 9'd0, 1'b1);
        // Data ends on a pad byte.
        send_byte(8'd2, 1'b1, 9'd6, 1'b0);
        send_byte(8'd1, 1'b0, 9'd0, 1'b0);
        send_byte(8'h33, 1'b0, 9'd0, 1'b0);
        send_byte(8'h00, 1'b0, 9'd0, 1'b1);
        // A terminator on the last byte still finishes the column.
        send_byte(pcpd_pkg::END_MARK, 1'b1, 9'd5, 1'b1);
    endtask

    task automatic test_register_extremes();
        set_config(1'b0, 1'b0, 1'b1, 9'd1, 17'h10000, 17'h0FFFF);
        send_columns_for(100);
        set_config(1'b1, 1'b0, 1'b1, 9'd0, 17'h0FFFF, 17'h10000);
        send_columns_for(100);
        set_config(1'b0, 1'b1, 1'b1, 9'd511, 17'h1FFFF, 17'h1FFFF);
        send_columns_for(100);
        set_config(1'b1, 1'b1, 1'b1, 9'd256, 17'($urandom), 17'($urandom));
        send_columns_for(100);
        set_config(1'b0, 1'b0, 1'b0, 9'd100, 17'h0FFFF, 17'h0FFFF);
        send_columns_for(100);
        set_config(1'b1, 1'b0, 1'b0, 9'd511, 17'h10000, 17'h10000);
        send_columns_for(100);
    endtask

    // The output is held off while a long post keeps arriving back to back.
    task automatic test_input_backpressure();
        set_config(1'b1, 1'b0, 1'b0, 9'd511, 17'($urandom), 17'($urandom));
        sender_steady = 1'b1;
        -> hold_off_request;
        send_byte(8'd0, 1'b1, 9'($urandom_range(0, 511)), 1'b0);
        send_byte(8'd200, 1'b0, 9'd0, 1'b0);
        for (int i = 0; i < 200; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0, 9'($urandom_range(0, 511)), 1'b0);
        send_byte(pcpd_pkg::END_MARK, 1'b0, 9'd0, 1'b0);
    endtask

    task automatic test_random_columns();
        int          pick;
        logic [8:0]  height;
        logic [16:0] ox;
        logic [16:0] oy;
        while (decoded_count < ITEM_TARGET) begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                height = 9'd0;
            else if (pick == 1)
                height = 9'd511;
            else
                height = 9'($urandom_range(1, 511));
            ox = ($urandom_range(0, 3) == 0) ? 17'h10000 : 17'($urandom);
            oy = ($urandom_range(0, 3) == 0) ? 17'h0FFFF : 17'($urandom);
            set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), height, ox, oy);
            send_columns_for(150);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_ignored_bytes();
        test_post_layout();
        test_restart_and_truncation();
        test_register_extremes();
        test_input_backpressure();
        test_random_columns();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
